[hw/rtl/rde_pkg.sv]
// Shared types, constants and helpers for the radix digit emitter.
`default_nettype none

package rde_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_VALUE_WIDTH = 63;
	localparam int DEF_UNARY_LIMIT = 63;

	// Register and code constants
	localparam logic [4:0] RADIX_RESET  = 5'd10;
	localparam logic [4:0] RADIX_MAX    = 5'd16;
	localparam logic [4:0] RADIX_UNARY  = 5'd1;
	localparam logic [6:0] NEWLINE_CODE = 7'd10;
	localparam logic [6:0] TALLY_CODE   = 7'd124;
	localparam logic [6:0] CHAR_ZERO    = 7'd48;
	localparam logic [6:0] CHAR_ALPHA   = 7'd55;

	// Digit store geometry: at most MAX_DIGITS digits per transaction
	localparam int STORE_AW   = 6;
	localparam int STORE_DEPTH = 64;
	localparam logic [STORE_AW-1:0] MAX_DIGITS = 6'd63;

	// Tally counter width covers UNARY_LIMIT up to 63
	localparam int TALLY_W = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_TALLY,
		ST_NEWLINE
	} state_t;

	typedef enum logic [1:0] {
		KIND_DIGIT,
		KIND_TALLY,
		KIND_NEWLINE
	} kind_t;

	// Divider commands from the sequencer
	typedef struct packed {
		logic load;
		logic cont;
	} div_ctrl_t;

	// Divider status back to the sequencer
	typedef struct packed {
		logic       done;
		logic       q_nonzero;
		logic [3:0] digit;
	} div_stat_t;

	// Map one digit to its ASCII character, 'A'-'F' above nine
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] dw;
		dw = {3'b000, d};
		if (d < 4'd10) begin
			return CHAR_ZERO + dw;
		end
		return CHAR_ALPHA + dw;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rde_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, quotient kept in place.
`default_nettype none

module rde_serial_div
	import rde_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire div_ctrl_t              ctrl,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic [4:0]             base,
	output div_stat_t                   stat
);

	localparam int BCW = $clog2(VALUE_WIDTH);
	localparam logic [BCW-1:0] BIT_LAST = BCW'(VALUE_WIDTH - 1);

	logic                   run_q;
	logic [BCW-1:0]         bit_q;
	logic [3:0]             rem_q;
	logic                   qnz_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic [4:0] trial;
	logic [4:0] diff;
	logic       qbit;
	logic [3:0] rem_next;

	// Trial subtract of the base from the shifted partial remainder
	assign trial    = {rem_q, val_q[VALUE_WIDTH-1]};
	assign qbit     = (trial >= base);
	assign diff     = trial - base;
	assign rem_next = qbit ? diff[3:0] : trial[3:0];

	// Report the digit on the last bit of a pass
	assign stat.done      = run_q && (bit_q == BIT_LAST);
	assign stat.q_nonzero = qnz_q | qbit;
	assign stat.digit     = rem_next;

	// Advance control of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			bit_q <= '0;
		end else if (ctrl.load || ctrl.cont) begin
			run_q <= 1'b1;
			bit_q <= '0;
		end else if (run_q) begin
			if (bit_q == BIT_LAST) begin
				run_q <= 1'b0;
			end
			bit_q <= bit_q + 1'b1;
		end
	end

	// Shift the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q <= value;
		end else if (run_q) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], qbit};
		end
		if (ctrl.load || ctrl.cont) begin
			rem_q <= '0;
			qnz_q <= 1'b0;
		end else if (run_q) begin
			rem_q <= rem_next;
			qnz_q <= qnz_q | qbit;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/radix_digit_emitter.sv]
// Top level of the radix digit emitter: sequencer, digit store and output stage.
//
// Usage: write radix with radix_we/radix_wdata while the block is idle (reset 10;
// 0 acts as 1, above 16 acts as 16). A transaction starts at a clock edge with
// start high and busy low; value is taken then. The block raises busy until
// its last character has been issued. Characters leave on char_code, last and
// saturated, each valid for one cycle with strobe high; the receiver cannot
// stall, so nothing ever waits at the output.
// Bases 2..16: the bit-serial divider produces one digit per pass over all
// VALUE_WIDTH bits, least significant first, into a 64-entry digit store;
// the digits are then read back most significant first at one per cycle,
// then newline. A transaction yields at most 63 digits at the default width
// (63 binary digits); zero gives the newline only. Base 1: one '|' per
// cycle, up to UNARY_LIMIT, then newline, with saturated set on every
// character when the tally was cut.
// Each character is registered in the issue stage and again in the output stage.
// Reset puts the sequencer in idle and clears the output strobe; the digit
// store needs no clearing since every entry is written before it is read.
`default_nettype none

module radix_digit_emitter
	import rde_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
	parameter int UNARY_LIMIT = DEF_UNARY_LIMIT
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   radix_we,
	input  wire logic [4:0]             radix_wdata,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        strobe,
	output logic [6:0]                  char_code,
	output logic                        last,
	output logic                        saturated
);

	localparam logic [TALLY_W-1:0] LIMIT_T = TALLY_W'(UNARY_LIMIT);

	state_t              state_q, state_d;
	logic [4:0]          radix_q;
	logic [4:0]          base_q;
	logic                sat_q;
	logic [TALLY_W-1:0]  tally_q;
	logic [STORE_AW-1:0] cnt_q;
	logic [STORE_AW-1:0] ptr_q;

	logic [3:0] store_mem [STORE_DEPTH];

	logic       vld_s1;
	kind_t      kind_s1;
	logic       sat_s1;
	logic [3:0] digit_s1;

	logic       strobe_q;
	logic [6:0] char_q;
	logic       last_q;
	logic       sat_out_q;

	div_ctrl_t div_ctrl;
	div_stat_t div_stat;

	logic               accept;
	logic [4:0]         base_in;
	logic               unary_in;
	logic               over_in;
	logic               val_nz;
	logic [TALLY_W-1:0] tally_in;
	logic               more;
	logic               wr_en;
	logic               iss_vld;
	kind_t              iss_kind;

	// Clamp the configured base and size the tally
	always_comb begin
		base_in = radix_q;
		if (radix_q == 5'd0) begin
			base_in = RADIX_UNARY;
		end else if (radix_q > RADIX_MAX) begin
			base_in = RADIX_MAX;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign unary_in = (base_in == RADIX_UNARY);
	assign over_in  = (value > VALUE_WIDTH'(UNARY_LIMIT));
	assign val_nz   = |value;
	assign tally_in = over_in ? LIMIT_T : value[TALLY_W-1:0];
	assign more     = div_stat.q_nonzero && (cnt_q < (MAX_DIGITS - 1'b1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (unary_in) begin
						state_d = (tally_in == '0) ? ST_NEWLINE : ST_TALLY;
					end else begin
						state_d = val_nz ? ST_DIV : ST_NEWLINE;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done && !more) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (ptr_q == '0) begin
					state_d = ST_NEWLINE;
				end
			end
			ST_TALLY: begin
				if (tally_q == TALLY_W'(1)) begin
					state_d = ST_NEWLINE;
				end
			end
			ST_NEWLINE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		div_ctrl.load = 1'b0;
		div_ctrl.cont = 1'b0;
		wr_en         = 1'b0;
		iss_vld       = 1'b0;
		iss_kind      = KIND_NEWLINE;
		case (state_q)
			ST_IDLE: begin
				div_ctrl.load = accept && !unary_in && val_nz;
			end
			ST_DIV: begin
				wr_en         = div_stat.done;
				div_ctrl.cont = div_stat.done && more;
			end
			ST_EMIT: begin
				iss_vld  = 1'b1;
				iss_kind = KIND_DIGIT;
			end
			ST_TALLY: begin
				iss_vld  = 1'b1;
				iss_kind = KIND_TALLY;
			end
			ST_NEWLINE: begin
				iss_vld  = 1'b1;
				iss_kind = KIND_NEWLINE;
			end
			default: begin
				iss_vld = 1'b0;
			end
		endcase
	end

	rde_serial_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (div_ctrl),
		.value (value),
		.base  (base_q),
		.stat  (div_stat)
	);

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	// Advance the sequencer and its counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			base_q  <= RADIX_RESET;
			sat_q   <= 1'b0;
			tally_q <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				base_q  <= base_in;
				sat_q   <= unary_in && over_in;
				tally_q <= tally_in;
				cnt_q   <= '0;
			end
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= cnt_q;
			end
			if (state_q == ST_EMIT) begin
				ptr_q <= ptr_q - 1'b1;
			end
			if (state_q == ST_TALLY) begin
				tally_q <= tally_q - 1'b1;
			end
		end
	end

	// Write digits as they finish; read them back most significant first
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[cnt_q] <= div_stat.digit;
		end
		if (iss_vld && (iss_kind == KIND_DIGIT)) begin
			digit_s1 <= store_mem[ptr_q];
		end
	end

	// Issue stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= iss_vld;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= iss_kind;
		sat_s1  <= sat_q && (iss_kind != KIND_DIGIT);
	end

	// Output stage: map to ASCII and register the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		case (kind_s1)
			KIND_DIGIT:   char_q <= digit_char(digit_s1);
			KIND_TALLY:   char_q <= TALLY_CODE;
			KIND_NEWLINE: char_q <= NEWLINE_CODE;
			default:      char_q <= NEWLINE_CODE;
		endcase
		last_q    <= (kind_s1 == KIND_NEWLINE);
		sat_out_q <= sat_s1;
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;
	assign saturated = sat_out_q;

	// The divider finishes a digit only while the sequencer divides
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider digit outside the divide phase");

	// Digit count never exceeds the store limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_DIGITS)
		else $error("digit count beyond store limit");

	// A closing character is always a newline
	a_last_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |-> (char_q == NEWLINE_CODE))
		else $error("last character is not a newline");

	// An accepted transaction raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accept");

	// Saturation only marks tally or newline characters
	a_sat_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && sat_out_q) |-> ((char_q == TALLY_CODE) || (char_q == NEWLINE_CODE)))
		else $error("saturated flag on a digit character");

endmodule

`default_nettype wire

[tb/sv/radix_digit_emitter_checker.sv]
// Checker for the radix digit emitter: predicts the character stream and compares it.
`timescale 1ns / 100ps

module radix_digit_emitter_checker
	import rde_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       radix_we,
	input  wire logic [4:0]                 radix_wdata,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic [DEF_VALUE_WIDTH-1:0] value,
	input  wire logic                       strobe,
	input  wire logic [6:0]                 char_code,
	input  wire logic                       last,
	input  wire logic                       saturated,
	output int                              fail_count,
	output int                              pending
);

	localparam int TALLY_LIMIT = DEF_UNARY_LIMIT;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
		logic       sat;
	} char_t;

	char_t      char_q[$];
	logic [4:0] radix_q;

	// Map one digit to its character, letters above nine
	function automatic logic [6:0] ascii_of(input logic [3:0] d);
		if (d < 4'd10) begin
			return 7'd48 + 7'(d);
		end
		return 7'd65 + 7'(d) - 7'd10;
	endfunction

	// Append one expected character at the tail
	function automatic void queue_char(input char_t c);
		char_q.insert(char_q.size(), c);
	endfunction

	// Queue every character one conversion is expected to produce
	function automatic void predict_text(input logic [DEF_VALUE_WIDTH-1:0] v,
			input logic [4:0] r);
		logic [4:0]                 base;
		logic [DEF_VALUE_WIDTH-1:0] rem;
		logic [3:0]                 digits[0:STORE_DEPTH-1];
		int                         n;
		logic                       sat;
		char_t                      c;
		base = r;
		if (base == 5'd0) begin
			base = RADIX_UNARY;
		end
		if (base > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		sat = 1'b0;
		n = 0;
		if (base == RADIX_UNARY) begin
			if (v > DEF_VALUE_WIDTH'(TALLY_LIMIT)) begin
				n = TALLY_LIMIT;
				sat = 1'b1;
			end else begin
				n = int'(v);
			end
			for (int i = 0; i < n; i++) begin
				c = '{code: TALLY_CODE, last: 1'b0, sat: sat};
				queue_char(c);
			end
		end else begin
			rem = v;
			while (rem != '0 && n < STORE_DEPTH - 1) begin
				digits[n] = 4'(rem % DEF_VALUE_WIDTH'(base));
				rem = rem / DEF_VALUE_WIDTH'(base);
				n++;
			end
			for (int i = n - 1; i >= 0; i--) begin
				c = '{code: ascii_of(digits[i]), last: 1'b0, sat: 1'b0};
				queue_char(c);
			end
		end
		c = '{code: NEWLINE_CODE, last: 1'b1, sat: sat};
		queue_char(c);
	endfunction

	// Track the radix register, check each character, predict each transaction
	always @(posedge clk or negedge arst_n) begin
		char_t exp_c;
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			char_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (strobe) begin
				if (char_q.size() == 0) begin
					$display("%0t: unexpected character: expected none, got code %0d last %0b sat %0b",
						$time, char_code, last, saturated);
					fail_count++;
				end else begin
					exp_c = char_q.pop_front();
					if (char_code !== exp_c.code) begin
						$display("%0t: char_code mismatch: expected %0d, got %0d",
							$time, exp_c.code, char_code);
						fail_count++;
					end
					if (last !== exp_c.last) begin
						$display("%0t: last mismatch: expected %0b, got %0b",
							$time, exp_c.last, last);
						fail_count++;
					end
					if (saturated !== exp_c.sat) begin
						$display("%0t: saturated mismatch: expected %0b, got %0b",
							$time, exp_c.sat, saturated);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_text(value, radix_q);
			end
			if (radix_we) begin
				radix_q <= radix_wdata;
			end
			pending <= char_q.size();
		end
	end

endmodule

[tb/sv/radix_digit_emitter_tb.sv]
// Top of the radix digit emitter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module radix_digit_emitter_tb
	import rde_pkg::*;
();

	localparam int VW         = DEF_VALUE_WIDTH;
	localparam int IDLE_LIMIT = 40000;
	localparam int PHASES     = 10;
	localparam int PER_PHASE  = 10;

	logic          clk;
	logic          arst_n;
	logic          radix_we;
	logic [4:0]    radix_wdata;
	logic          start;
	logic          busy;
	logic [VW-1:0] value;
	logic          strobe;
	logic [6:0]    char_code;
	logic          last;
	logic          saturated;
	int            fail_count;
	int            pending;
	int            idle_cycles;
	logic          no_gaps;

	radix_digit_emitter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.strobe      (strobe),
		.char_code   (char_code),
		.last        (last),
		.saturated   (saturated)
	);

	radix_digit_emitter_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.strobe      (strobe),
		.char_code   (char_code),
		.last        (last),
		.saturated   (saturated),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort when no transaction, character or register write moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || radix_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one value after a random gap and hold it until accepted
	task automatic send_value(input logic [VW-1:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Hold off until every expected character has come and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	task automatic write_radix(input logic [4:0] r);
		drain();
		radix_we <= 1'b1;
		radix_wdata <= r;
		@(posedge clk);
		radix_we <= 1'b0;
	endtask

	// Mostly narrow values to keep division short, a quarter at full width
	function automatic logic [VW-1:0] random_value();
		logic [VW-1:0] v;
		int            w;
		v = VW'({$urandom, $urandom});
		w = $urandom_range(1, VW - 1);
		if ($urandom_range(0, 3) != 0) begin
			v = v & ((VW'(1) << w) - VW'(1));
		end
		return v;
	endfunction

	initial begin
		logic [4:0] r;
		idle_cycles = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		radix_we = 1'b0;
		radix_wdata = '0;
		start = 1'b0;
		value = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default decimal, then each base class and its corner values
		send_value('0);
		send_value(VW'(1));
		send_value(VW'(9));
		send_value(VW'(10));
		send_value('1);
		send_value(VW'(1) << (VW - 1));
		write_radix(RADIX_MAX);
		send_value(VW'(64'h7EDC_BA98_7654_3210));
		send_value(VW'(15));
		send_value(VW'(16));
		write_radix(5'd2);
		send_value('1);
		send_value(VW'(1));
		send_value(VW'(2));
		write_radix(RADIX_UNARY);
		send_value('0);
		send_value(VW'(1));
		send_value(VW'(62));
		send_value(VW'(63));
		send_value(VW'(64));
		send_value('1);
		write_radix(5'd0);
		send_value(VW'(5));
		send_value(VW'(100));
		write_radix(5'd31);
		send_value(VW'(255));
		write_radix(5'd17);
		send_value(VW'(4095));
		write_radix(5'd3);
		send_value(VW'(64'h5555_5555_5555_5555));

		// Random: one radix per phase, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: r = RADIX_UNARY;
				1: r = RADIX_MAX;
				2: r = 5'd0;
				3: r = 5'd31;
				4: r = 5'd2;
				default: r = 5'($urandom_range(0, 31));
			endcase
			write_radix(r);
			no_gaps = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PER_PHASE; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					drain();
				end
				send_value(random_value());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
